// ===== rtl/core/bdlp_pkg.sv =====
// bdlp_pkg: shared types and constants for the button debounce / long-press unit
// holds the item and result structs, register indexes and reset values
// no dependencies
package bdlp_pkg;

  localparam int NUM_BUTTONS = 3;
  localparam int CNT_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [CNT_W-1:0] LONG_RESET = CNT_W'(300);
  localparam logic [CNT_W-1:0] IDLE_RESET = CNT_W'(1000);

  localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IDLE_TIMEOUT = CFG_IDX_W'(1);

  typedef logic [NUM_BUTTONS-1:0] btn_mask_t;
  typedef logic [CNT_W-1:0]       cnt_t;

  typedef enum logic {
    REQ_TICK = 1'b0,
    REQ_ACK  = 1'b1
  } req_t;

  typedef struct packed {
    req_t      req_type;
    btn_mask_t raw_levels;
    btn_mask_t ack_press;
    btn_mask_t ack_long;
  } item_t;

  typedef struct packed {
    btn_mask_t press_pending;
    btn_mask_t long_pending;
    btn_mask_t stable_levels;
    logic      idle_expired;
  } result_t;

endpackage

// ===== rtl/core/bdlp_engine.sv =====
// bdlp_engine: debounce state, hold counters, sticky flags and idle timer
// updates all state for one transaction and gives the result from the next values
// depends on bdlp_pkg
module bdlp_engine import bdlp_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    step,
  input  item_t   item,
  input  cnt_t    long_ticks,
  input  cnt_t    idle_ticks,
  output result_t result
);

  btn_mask_t hist_r [3];
  btn_mask_t hist_nxt [3];
  btn_mask_t stable_r, stable_nxt;
  btn_mask_t press_r, press_nxt;
  btn_mask_t long_r, long_nxt;
  cnt_t      hold_r [NUM_BUTTONS];
  cnt_t      hold_nxt [NUM_BUTTONS];
  cnt_t      idle_r, idle_nxt;
  btn_mask_t agree;
  logic      reload;

  always_comb begin
    press_nxt  = press_r & ~item.ack_press;
    long_nxt   = long_r & ~item.ack_long;
    hist_nxt   = hist_r;
    stable_nxt = stable_r;
    hold_nxt   = hold_r;
    idle_nxt   = idle_r;
    agree      = '0;
    reload     = 1'b0;
    if (item.req_type == REQ_TICK) begin
      if (idle_r != '0) begin
        idle_nxt = idle_r - CNT_W'(1);
      end
      hist_nxt[0] = item.raw_levels;
      hist_nxt[1] = hist_r[0];
      hist_nxt[2] = hist_r[1];
      agree = ~(hist_nxt[0] ^ hist_nxt[1]) & ~(hist_nxt[1] ^ hist_nxt[2]);
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        if (agree[b]) begin
          if (stable_r[b] != hist_nxt[2][b]) begin
            stable_nxt[b] = hist_nxt[2][b];
            // new press edge
            if (!hist_nxt[2][b]) begin
              press_nxt[b] = 1'b1;
              hold_nxt[b]  = long_ticks;
              reload       = 1'b1;
            end
          end else if (hold_r[b] <= CNT_W'(1)) begin
            // hold period expired, long press only while held
            if (!hist_nxt[2][b]) begin
              long_nxt[b] = 1'b1;
              reload      = 1'b1;
            end
            hold_nxt[b] = long_ticks;
          end else begin
            hold_nxt[b] = hold_r[b] - CNT_W'(1);
          end
        end
      end
      if (reload) begin
        idle_nxt = idle_ticks;
      end
    end
  end

  assign result.press_pending = press_nxt;
  assign result.long_pending  = long_nxt;
  assign result.stable_levels = stable_nxt;
  assign result.idle_expired  = (idle_nxt == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_r   <= '{default: '1};
      stable_r <= '1;
      press_r  <= '0;
      long_r   <= '0;
      hold_r   <= '{default: LONG_RESET};
      idle_r   <= IDLE_RESET;
    end else if (step) begin
      hist_r   <= hist_nxt;
      stable_r <= stable_nxt;
      press_r  <= press_nxt;
      long_r   <= long_nxt;
      hold_r   <= hold_nxt;
      idle_r   <= idle_nxt;
    end
  end

endmodule

// ===== rtl/core/button_debounce_long_press_unit.sv =====
// button_debounce_long_press_unit: top level with input register, update engine
// and result register; depends on bdlp_pkg and bdlp_engine
// an accepted transaction is held in the input register, and its result is then loaded into the result register
// throughput: one transaction per cycle while out_ready does not stall the result register
// reset: synchronous active-low rst_n; registers return to 300 and 1000 ticks,
// buttons to released, flags cleared, both pipeline stages emptied
module button_debounce_long_press_unit import bdlp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_req_type,
  input  logic [2:0]           in_raw_levels,
  input  logic [2:0]           in_ack_press,
  input  logic [2:0]           in_ack_long,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_press_pending,
  output logic [2:0]           out_long_pending,
  output logic [2:0]           out_stable_levels,
  output logic                 out_idle_expired,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CNT_W-1:0]     cfg_wdata
);

  cnt_t    long_ticks_r;
  cnt_t    idle_ticks_r;
  logic    s1_valid_r;
  item_t   s1_item_r;
  logic    s1_go;
  logic    out_valid_r;
  result_t out_res_r;
  result_t eng_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      long_ticks_r <= LONG_RESET;
      idle_ticks_r <= IDLE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LONG_PRESS:   long_ticks_r <= cfg_wdata;
        REG_IDLE_TIMEOUT: idle_ticks_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // stage 1 moves into the result register when that is free or being drained
  assign s1_go    = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r.req_type   <= req_t'(in_req_type);
      s1_item_r.raw_levels <= btn_mask_t'(in_raw_levels);
      s1_item_r.ack_press  <= btn_mask_t'(in_ack_press);
      s1_item_r.ack_long   <= btn_mask_t'(in_ack_long);
    end
  end

  bdlp_engine u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (s1_go),
    .item       (s1_item_r),
    .long_ticks (long_ticks_r),
    .idle_ticks (idle_ticks_r),
    .result     (eng_result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_res_r <= eng_result;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_press_pending = 3'(out_res_r.press_pending);
  assign out_long_pending  = 3'(out_res_r.long_pending);
  assign out_stable_levels = 3'(out_res_r.stable_levels);
  assign out_idle_expired  = out_res_r.idle_expired;

`ifndef SYNTHESIS
  a_ready_low_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid_r && out_valid_r && !out_ready))
    else $error("in_ready low while pipeline can move");

  a_s1_holds_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_go) |=> (s1_valid_r && $stable(s1_item_r)))
    else $error("stage 1 transaction lost while stalled");

  a_ack_only_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_go && s1_item_r.req_type == REQ_ACK) |=>
      ((out_res_r.press_pending & $past(s1_item_r.ack_press)) == '0 &&
       (out_res_r.long_pending & $past(s1_item_r.ack_long)) == '0))
    else $error("acknowledged flag still pending after acknowledge-only step");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("result register not loaded after stage 1 moved");
`endif

endmodule

// ===== bench/button_debounce_long_press_unit_tb.sv =====
// testbench for button_debounce_long_press_unit: directed and random tick/ack traffic
// with random stalls on both channels, checked against a cycle-free predictor
// depends on bdlp_pkg and the button_debounce_long_press_unit rtl
module button_debounce_long_press_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdlp_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  class debounce_scoreboard;
    cnt_t      long_ticks;
    cnt_t      idle_ticks;
    btn_mask_t history [3];
    btn_mask_t level;
    btn_mask_t press_f;
    btn_mask_t long_f;
    cnt_t      hold [NUM_BUTTONS];
    cnt_t      idle_cnt;
    result_t   expected_q [$];
    int        mismatches;
    int        checked;
    int        ticks;
    int        acks;
    int        press_events;
    int        long_events;
    int        idle_results;

    function new();
      long_ticks = LONG_RESET;
      idle_ticks = IDLE_RESET;
      for (int i = 0; i < 3; i++) history[i] = '1;
      level = '1;
      press_f = '0;
      long_f = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) hold[b] = LONG_RESET;
      idle_cnt = IDLE_RESET;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, cnt_t data);
      case (idx)
        REG_LONG_PRESS: begin
          long_ticks = data;
        end
        REG_IDLE_TIMEOUT: begin
          idle_ticks = data;
        end
        default: begin
        end
      endcase
    endfunction

    // advance the debouncer by one accepted transaction and queue its result
    function void note_input(item_t it);
      result_t   r;
      btn_mask_t agree;
      press_f &= ~it.ack_press;
      long_f &= ~it.ack_long;
      if (it.req_type == REQ_TICK) begin
        ticks++;
        if (idle_cnt != 0) idle_cnt--;
        history[2] = history[1];
        history[1] = history[0];
        history[0] = it.raw_levels;
        agree = ~(history[0] ^ history[1]) & ~(history[1] ^ history[2]);
        for (int b = 0; b < NUM_BUTTONS; b++) begin
          if (agree[b]) begin
            if (level[b] != history[2][b]) begin
              level[b] = history[2][b];
              if (!history[2][b]) begin
                press_f[b] = 1'b1;
                press_events++;
                idle_cnt = idle_ticks;
                hold[b] = long_ticks;
              end
            end else if (hold[b] <= 1) begin
              // expiry reloads for either level, only a held button reports it
              if (!history[2][b]) begin
                long_f[b] = 1'b1;
                long_events++;
                idle_cnt = idle_ticks;
              end
              hold[b] = long_ticks;
            end else begin
              hold[b]--;
            end
          end
        end
      end else begin
        acks++;
      end
      r.press_pending = press_f;
      r.long_pending = long_f;
      r.stable_levels = level;
      r.idle_expired = (idle_cnt == 0);
      if (r.idle_expired) idle_results++;
      expected_q.push_back(r);
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result transaction with nothing expected: press=%b long=%b level=%b idle=%b",
                   $realtime, got.press_pending, got.long_pending, got.stable_levels,
                   got.idle_expired);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (got.press_pending !== want.press_pending || got.long_pending !== want.long_pending ||
          got.stable_levels !== want.stable_levels || got.idle_expired !== want.idle_expired) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%t: result %0d differs: expected press=%b long=%b level=%b idle=%b, got press=%b long=%b level=%b idle=%b",
                   $realtime, checked, want.press_pending, want.long_pending,
                   want.stable_levels, want.idle_expired, got.press_pending,
                   got.long_pending, got.stable_levels, got.idle_expired);
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 in_req_type = 1'b0;
  logic [2:0]           in_raw_levels = '1;
  logic [2:0]           in_ack_press = '0;
  logic [2:0]           in_ack_long = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [2:0]           out_press_pending;
  logic [2:0]           out_long_pending;
  logic [2:0]           out_stable_levels;
  logic                 out_idle_expired;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CNT_W-1:0]     cfg_wdata = '0;

  debounce_scoreboard sb = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int dead_cycles = 0;

  button_debounce_long_press_unit dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_req_type(in_req_type),
    .in_raw_levels(in_raw_levels),
    .in_ack_press(in_ack_press),
    .in_ack_long(in_ack_long),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_press_pending(out_press_pending),
    .out_long_pending(out_long_pending),
    .out_stable_levels(out_stable_levels),
    .out_idle_expired(out_idle_expired),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side: check each transaction, then hold ready low for a drawn stall
  always @(posedge clk) begin
    result_t got;
    if (rst_n && out_valid && out_ready) begin
      got.press_pending = out_press_pending;
      got.long_pending = out_long_pending;
      got.stable_levels = out_stable_levels;
      got.idle_expired = out_idle_expired;
      sb.check_result(got);
      stall_left = quiet ? 0 : $urandom_range(0, 8);
    end
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      dead_cycles = 0;
    end else begin
      dead_cycles++;
      if (dead_cycles >= WATCHDOG_LIMIT) begin
        $display("%t: no transaction for %0d cycles, %0d results outstanding",
                 $realtime, dead_cycles, sb.expected_q.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  task automatic send(req_t req, btn_mask_t raw, btn_mask_t ap, btn_mask_t al);
    item_t it;
    int    gap;
    it.req_type = req;
    it.raw_levels = raw;
    it.ack_press = ap;
    it.ack_long = al;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_req_type <= it.req_type;
    in_raw_levels <= it.raw_levels;
    in_ack_press <= it.ack_press;
    in_ack_long <= it.ack_long;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(it);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, cnt_t data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    sb.write_reg(idx, data);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_regs(cnt_t long_val, cnt_t idle_val);
    wait_idle();
    write_reg(REG_LONG_PRESS, long_val);
    write_reg(REG_IDLE_TIMEOUT, idle_val);
  endtask

  // mostly clean press/release sequences, with contact bounce, noise and acks mixed in
  task automatic run_random(int n, int flip_odds);
    btn_mask_t intent;
    btn_mask_t raw;
    btn_mask_t ap;
    btn_mask_t al;
    intent = '1;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(0, 39) == 0) quiet = ~quiet;
      ap = ($urandom_range(0, 3) == 0) ? btn_mask_t'($urandom) : '0;
      al = ($urandom_range(0, 3) == 0) ? btn_mask_t'($urandom) : '0;
      if ($urandom_range(0, 99) < 12) begin
        send(REQ_ACK, btn_mask_t'($urandom), ap, al);
      end else begin
        for (int b = 0; b < NUM_BUTTONS; b++)
          if ($urandom_range(0, flip_odds - 1) == 0) intent[b] = ~intent[b];
        raw = intent;
        if ($urandom_range(0, 9) == 0)
          raw ^= btn_mask_t'(1 << $urandom_range(0, NUM_BUTTONS - 1));
        else if ($urandom_range(0, 19) == 0)
          raw = btn_mask_t'($urandom);
        send(REQ_TICK, raw, ap, al);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: acks on empty flags, full press, ack while held, release, bounce
    send(REQ_ACK, 3'b000, 3'b111, 3'b111);
    repeat (3) send(REQ_TICK, 3'b000, 3'b000, 3'b000);
    send(REQ_TICK, 3'b000, 3'b111, 3'b000);
    send(REQ_ACK, 3'b111, 3'b010, 3'b101);
    repeat (3) send(REQ_TICK, 3'b111, 3'b000, 3'b000);
    send(REQ_TICK, 3'b010, 3'b000, 3'b000);
    send(REQ_TICK, 3'b101, 3'b000, 3'b000);

    // zero hold count and zero idle timeout
    set_regs('0, '0);
    repeat (3) send(REQ_TICK, 3'b110, 3'b000, 3'b000);
    repeat (2) send(REQ_TICK, 3'b110, 3'b000, 3'b000);
    send(REQ_ACK, 3'b110, 3'b000, 3'b001);
    repeat (3) send(REQ_TICK, 3'b111, 3'b000, 3'b000);

    // idle counter runs into zero and stays there
    set_regs('1, cnt_t'(2));
    repeat (6) send(REQ_TICK, 3'b011, 3'b000, 3'b000);

    set_regs(cnt_t'(3), cnt_t'(10));
    run_random(180, 12);
    set_regs(cnt_t'(1), cnt_t'(1));
    run_random(150, 8);
    set_regs('0, '0);
    run_random(120, 10);
    set_regs('1, '1);
    run_random(120, 12);
    set_regs(cnt_t'(6), cnt_t'(25));
    run_random(200, 20);
    // spare register indexes must have no effect
    wait_idle();
    write_reg(REG_SPARE_LO, cnt_t'($urandom));
    write_reg(REG_SPARE_HI, cnt_t'($urandom));
    set_regs(cnt_t'(2), cnt_t'(4));
    run_random(150, 10);

    wait_idle();
    repeat (8) @(posedge clk);
    $display("covered %0d tick and %0d ack-only transactions, %0d results checked",
             sb.ticks, sb.acks, sb.checked);
    $display("predicted %0d press events, %0d long presses, %0d idle reports; %0d left unmatched",
             sb.press_events, sb.long_events, sb.idle_results, sb.expected_q.size());
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/bdlp_pkg.sv
rtl/core/bdlp_engine.sv
rtl/core/button_debounce_long_press_unit.sv
bench/button_debounce_long_press_unit_tb.sv
